// ===== rtl/pfs_pkg.sv =====
// ----------------------------------------------------------------------------
// pfs_pkg: shared types and constants of the paper feed sensor sequencer
// event codes, register indexes, payload structs and register file struct
// ----------------------------------------------------------------------------
package pfs_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned DelayW  = 16;
  localparam int unsigned MsW     = 32;
  localparam int unsigned PhaseW  = 3;

  localparam logic [DelayW-1:0] HallMax = {DelayW{1'b1}};
  localparam logic [MsW-1:0]    MsMax   = {MsW{1'b1}};

  // event codes carried in the op field
  typedef enum logic [1:0] {
    OpTick  = 2'd0,
    OpHall  = 2'd1,
    OpPanel = 2'd2,
    OpNone  = 2'd3
  } op_e;

  // register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CfgPowerOn    = 3'd0,
    CfgClutch     = 3'd1,
    CfgExitOn     = 3'd2,
    CfgManualOff  = 3'd3,
    CfgPaperInOff = 3'd4,
    CfgExitOff    = 3'd5,
    CfgHallTmo    = 3'd6,
    CfgUnused     = 3'd7
  } cfg_idx_e;

  // phase codes as they appear on the result
  localparam logic [PhaseW-1:0] PhIdle   = 3'd1;
  localparam logic [PhaseW-1:0] PhClutch = 3'd2;

  typedef struct packed {
    logic [1:0] op;
    logic       paper_sensor;
  } in_item_t;

  typedef struct packed {
    logic              clutch;
    logic              paper_in_out;
    logic              manual_feed_out;
    logic              exit_out;
    logic              led_red;
    logic              led_yellow;
    logic              led_green;
    logic [PhaseW-1:0] phase;
  } out_item_t;

  typedef struct packed {
    logic [DelayW-1:0] power_on_ms;
    logic [DelayW-1:0] clutch_ms;
    logic [DelayW-1:0] exit_on_ms;
    logic [DelayW-1:0] manual_off_ms;
    logic [DelayW-1:0] paper_in_off_ms;
    logic [DelayW-1:0] exit_off_ms;
    logic [DelayW-1:0] hall_timeout_ms;
  } cfg_t;

endpackage

// ===== rtl/pfs_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pfs_cfg_regs: configuration register file
// seven 16-bit delay registers written through an index and data channel
// ----------------------------------------------------------------------------
module pfs_cfg_regs
  import pfs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [CfgIdxW-1:0] wr_idx_i,
  input  logic [DelayW-1:0]  wr_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  // decode the write index, writes past the list are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (cfg_idx_e'(wr_idx_i))
        CfgPowerOn:    cfg_d.power_on_ms     = wr_data_i;
        CfgClutch:     cfg_d.clutch_ms       = wr_data_i;
        CfgExitOn:     cfg_d.exit_on_ms      = wr_data_i;
        CfgManualOff:  cfg_d.manual_off_ms   = wr_data_i;
        CfgPaperInOff: cfg_d.paper_in_off_ms = wr_data_i;
        CfgExitOff:    cfg_d.exit_off_ms     = wr_data_i;
        CfgHallTmo:    cfg_d.hall_timeout_ms = wr_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.power_on_ms     <= 16'd1000;
      cfg_q.clutch_ms       <= 16'd100;
      cfg_q.exit_on_ms      <= 16'd100;
      cfg_q.manual_off_ms   <= 16'd100;
      cfg_q.paper_in_off_ms <= 16'd100;
      cfg_q.exit_off_ms     <= 16'd100;
      cfg_q.hall_timeout_ms <= 16'd200;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/pfs_seq_core.sv =====
// ----------------------------------------------------------------------------
// pfs_seq_core: event handling and sequencer state
// applies one event to the counters, evaluates the sequencer once and
// holds the phase, millisecond counter, hall timer and pin levels
// ----------------------------------------------------------------------------
module pfs_seq_core
  import pfs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t result_o
);

  typedef enum logic [PhaseW-1:0] {
    PowerOn   = 3'd0,
    Idle      = 3'd1,
    ClutchDly = 3'd2,
    WaitPaper = 3'd3,
    ExitOn    = 3'd4,
    ManualOff = 3'd5,
    PaperOff  = 3'd6,
    ExitOff   = 3'd7
  } phase_e;

  phase_e            phase_q, phase_d, phase_ev;
  logic [MsW-1:0]    ms_q, ms_d, ms_ev;
  logic [DelayW-1:0] hall_q, hall_d;
  logic              clutch_q, clutch_d;
  logic              paper_q, paper_d;
  logic              manual_q, manual_d;
  logic              exit_q, exit_d;
  logic              red_q, red_d;
  logic              yellow_q, yellow_d;
  logic              green_q, green_d;

  // millisecond counter against a 16-bit delay
  function automatic logic ms_reached(logic [MsW-1:0] ms, logic [DelayW-1:0] dly);
    return (ms[MsW-1:DelayW] != '0) || (ms[DelayW-1:0] >= dly);
  endfunction

  // apply the event, then evaluate the sequencer once
  always_comb begin
    phase_ev = phase_q;
    ms_ev    = ms_q;
    hall_d   = hall_q;
    yellow_d = yellow_q;
    case (op_e'(item_i.op))
      OpTick: begin
        if (ms_q != MsMax) ms_ev = ms_q + 1'b1;
        if (phase_q != PowerOn) begin
          if (hall_q != HallMax) hall_d = hall_q + 1'b1;
          yellow_d = (hall_d < cfg_i.hall_timeout_ms);
        end
      end
      OpHall:  hall_d = '0;
      OpPanel: begin
        if (phase_q == ClutchDly || phase_q == WaitPaper) phase_ev = Idle;
      end
      default: ;
    endcase

    phase_d  = phase_ev;
    ms_d     = ms_ev;
    clutch_d = clutch_q;
    paper_d  = paper_q;
    manual_d = manual_q;
    exit_d   = exit_q;
    red_d    = red_q;
    green_d  = green_q;
    case (phase_ev)
      PowerOn: begin
        if (ms_reached(ms_ev, cfg_i.power_on_ms)) phase_d = Idle;
      end
      Idle: begin
        paper_d  = 1'b1;
        manual_d = 1'b1;
        exit_d   = 1'b1;
        red_d    = 1'b1;
        clutch_d = 1'b0;
        green_d  = 1'b0;
        // motor running and no paper: grab the carrier
        if (hall_d < cfg_i.hall_timeout_ms && !item_i.paper_sensor) begin
          clutch_d = 1'b1;
          green_d  = 1'b1;
          red_d    = 1'b0;
          phase_d  = ClutchDly;
          ms_d     = '0;
        end
      end
      ClutchDly: begin
        if (ms_reached(ms_ev, cfg_i.clutch_ms)) begin
          clutch_d = 1'b0;
          manual_d = 1'b0;
          phase_d  = WaitPaper;
        end
      end
      WaitPaper: begin
        if (item_i.paper_sensor) begin
          paper_d = 1'b0;
          red_d   = 1'b1;
          ms_d    = '0;
          phase_d = ExitOn;
        end
      end
      ExitOn: begin
        if (ms_reached(ms_ev, cfg_i.exit_on_ms)) begin
          exit_d  = 1'b0;
          ms_d    = '0;
          phase_d = ManualOff;
        end
      end
      ManualOff: begin
        if (ms_reached(ms_ev, cfg_i.manual_off_ms)) begin
          manual_d = 1'b1;
          ms_d     = '0;
          phase_d  = PaperOff;
        end
      end
      PaperOff: begin
        if (ms_reached(ms_ev, cfg_i.paper_in_off_ms)) begin
          paper_d = 1'b1;
          ms_d    = '0;
          phase_d = ExitOff;
        end
      end
      default: begin
        if (ms_reached(ms_ev, cfg_i.exit_off_ms)) begin
          exit_d  = 1'b1;
          ms_d    = '0;
          phase_d = Idle;
        end
      end
    endcase
  end

  // state and pin levels advance once per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PowerOn;
      ms_q     <= '0;
      hall_q   <= HallMax;
      clutch_q <= 1'b1;
      paper_q  <= 1'b1;
      manual_q <= 1'b1;
      exit_q   <= 1'b1;
      red_q    <= 1'b1;
      yellow_q <= 1'b1;
      green_q  <= 1'b1;
    end else if (step_i) begin
      phase_q  <= phase_d;
      ms_q     <= ms_d;
      hall_q   <= hall_d;
      clutch_q <= clutch_d;
      paper_q  <= paper_d;
      manual_q <= manual_d;
      exit_q   <= exit_d;
      red_q    <= red_d;
      yellow_q <= yellow_d;
      green_q  <= green_d;
    end
  end

  assign result_o.clutch          = clutch_d;
  assign result_o.paper_in_out    = paper_d;
  assign result_o.manual_feed_out = manual_d;
  assign result_o.exit_out        = exit_d;
  assign result_o.led_red         = red_d;
  assign result_o.led_yellow      = yellow_d;
  assign result_o.led_green       = green_d;
  assign result_o.phase           = phase_d;

endmodule

// ===== rtl/paper_feed_sensor_sequencer.sv =====
// ----------------------------------------------------------------------------
// paper_feed_sensor_sequencer: paper feed sensor emulation sequencer
// event driven sequencer for clutch, emulated sensors and LEDs
// ----------------------------------------------------------------------------
// Usage
//   in channel  (in_valid_i/in_ready_o/in_i): one event item per
//     handshake, a millisecond tick, a hall edge or a panel press,
//     together with the paper-in sensor level
//   out channel (out_valid_o/out_ready_i/out_o): one result item per
//     event, the pin levels and phase after the event is applied
//   cfg channel (cfg_valid_i/cfg_ready_o): register index and 16-bit
//     data, always ready, to be written while no event is in flight (the block does not enforce this)
// The event sits in the input register while the sequencer logic works
// on it, and the result register loads the outcome when the item
// advances. Throughput is one item per cycle while the receiver keeps
// taking results, as the sequencer core updates its state once per item.
// Reset loads the default delays, puts the sequencer into power-on
// wait with all pins high and empties both registers. When the
// receiver stalls the result register holds its item, the input
// register keeps one more, and in_ready_o falls once both are full.
// ----------------------------------------------------------------------------
module paper_feed_sensor_sequencer
  import pfs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DelayW-1:0]  cfg_data_i
);

  logic      in_vld_q;
  in_item_t  in_q;
  logic      out_vld_q;
  out_item_t out_q;
  logic      advance;
  cfg_t      cfg;
  out_item_t result;

  assign cfg_ready_o = 1'b1;

  pfs_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  // the held item moves on whenever the result register is free
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  pfs_seq_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

endmodule

// ===== rtl/pfs_checker.sv =====
// ----------------------------------------------------------------------------
// pfs_checker: port level checks of the paper feed sensor sequencer
// handshake hold, result timing and pin levels per phase
// ----------------------------------------------------------------------------
module pfs_checker
  import pfs_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("result changed while stalled");

  // a fresh result follows an accepted item through the input and result registers
  a_out_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without matching item");

  // clutch is held exactly during clutch delay in the phases past idle
  a_clutch_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.phase >= PhClutch |-> out_o.clutch == (out_o.phase == PhClutch))
    else $error("clutch level does not match phase");

  // idle releases every emulated sensor and shows red
  a_idle_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.phase == PhIdle |->
      out_o.paper_in_out && out_o.manual_feed_out && out_o.exit_out &&
      out_o.led_red)
    else $error("idle pin levels wrong");

endmodule

bind paper_feed_sensor_sequencer pfs_checker u_pfs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o)
);

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the paper feed sensor sequencer
// drives tick, hall and panel events with the paper level through the
// valid/ready input, predicts the pins and phase of every event and
// compares each result item field by field, under several delay settings
// and with a long stall on the receiver and idling on both sides
// ----------------------------------------------------------------------------
module testbench;
  import pfs_pkg::*;

  // sequencer phases as reported on the result
  typedef enum logic [PhaseW-1:0] {
    SqPowerOn    = 3'd0,
    SqIdle       = 3'd1,
    SqClutch     = 3'd2,
    SqWaitPaper  = 3'd3,
    SqExitOn     = 3'd4,
    SqManualOff  = 3'd5,
    SqPaperInOff = 3'd6,
    SqExitOff    = 3'd7
  } seq_e;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_ready_o;
  in_item_t           in_data     = '0;
  logic               out_valid_o;
  logic               out_ready   = 1'b0;
  out_item_t          out_o;
  logic               cfg_valid   = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index   = '0;
  logic [DelayW-1:0]  cfg_data    = '0;

  // stimulus and checking state
  in_item_t  event_backlog[$];
  out_item_t pins_due[$];
  out_item_t due;
  int        events_queued = 0;
  int        mismatches    = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        hold_asked    = 0;
  int        hold_taken    = 0;
  int        hold_left     = 0;
  bit        in_taken      = 1'b0;

  // predictor state
  cfg_t             timing;
  seq_e             seq_state;
  logic [MsW-1:0]   ms_elapsed;
  logic [DelayW-1:0] hall_age;
  out_item_t        pin_state;

  paper_feed_sensor_sequencer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_i        (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_o       (out_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // apply one event, then evaluate the sequencer once
  function automatic out_item_t advance_sequencer(in_item_t ev);
    logic paper;
    paper = ev.paper_sensor;
    case (ev.op)
      OpTick: begin
        if (ms_elapsed != MsMax) ms_elapsed = ms_elapsed + 1;
        if (seq_state != SqPowerOn) begin
          if (hall_age != HallMax) hall_age = hall_age + 1'b1;
          pin_state.led_yellow = hall_age < timing.hall_timeout_ms;
        end
      end
      OpHall: hall_age = '0;
      OpPanel: begin
        if (seq_state == SqClutch || seq_state == SqWaitPaper) seq_state = SqIdle;
      end
      default: ;
    endcase
    case (seq_state)
      SqPowerOn: begin
        if (ms_elapsed >= timing.power_on_ms) seq_state = SqIdle;
      end
      SqIdle: begin
        pin_state.paper_in_out    = 1'b1;
        pin_state.manual_feed_out = 1'b1;
        pin_state.exit_out        = 1'b1;
        pin_state.led_red         = 1'b1;
        pin_state.clutch          = 1'b0;
        pin_state.led_green       = 1'b0;
        // motor running and no paper: engage the clutch
        if (hall_age < timing.hall_timeout_ms && !paper) begin
          pin_state.clutch    = 1'b1;
          pin_state.led_green = 1'b1;
          pin_state.led_red   = 1'b0;
          seq_state  = SqClutch;
          ms_elapsed = '0;
        end
      end
      SqClutch: begin
        // counter deliberately left running into wait for paper
        if (ms_elapsed >= timing.clutch_ms) begin
          pin_state.clutch          = 1'b0;
          pin_state.manual_feed_out = 1'b0;
          seq_state = SqWaitPaper;
        end
      end
      SqWaitPaper: begin
        if (paper) begin
          pin_state.paper_in_out = 1'b0;
          pin_state.led_red      = 1'b1;
          ms_elapsed = '0;
          seq_state  = SqExitOn;
        end
      end
      SqExitOn: begin
        if (ms_elapsed >= timing.exit_on_ms) begin
          pin_state.exit_out = 1'b0;
          ms_elapsed = '0;
          seq_state  = SqManualOff;
        end
      end
      SqManualOff: begin
        if (ms_elapsed >= timing.manual_off_ms) begin
          pin_state.manual_feed_out = 1'b1;
          ms_elapsed = '0;
          seq_state  = SqPaperInOff;
        end
      end
      SqPaperInOff: begin
        // one phase per event, no fall through into exit-off
        if (ms_elapsed >= timing.paper_in_off_ms) begin
          pin_state.paper_in_out = 1'b1;
          ms_elapsed = '0;
          seq_state  = SqExitOff;
        end
      end
      default: begin
        if (ms_elapsed >= timing.exit_off_ms) begin
          pin_state.exit_out = 1'b1;
          ms_elapsed = '0;
          seq_state  = SqIdle;
        end
      end
    endcase
    pin_state.phase = seq_state;
    return pin_state;
  endfunction

  function automatic void compare_field(string field, logic [2:0] want, logic [2:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  // delays are clipped so that a cycle stays short under large settings
  function automatic int capped(logic [DelayW-1:0] ms);
    return (ms > 12) ? 12 : int'(ms);
  endfunction

  // input driver, fed from the backlog
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (event_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= event_backlog.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random idling, or a long hold-off when asked
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_taken != hold_asked) begin
      out_ready  <= 1'b0;
      hold_left  <= 299;
      hold_taken <= hold_asked;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: check results, predict on every accepted item
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) begin
      if (pins_due.size() == 0) begin
        $error("result item with no item pending");
        mismatches++;
      end else begin
        due = pins_due.pop_front();
        compare_field("clutch", due.clutch, out_o.clutch);
        compare_field("paper_in_out", due.paper_in_out, out_o.paper_in_out);
        compare_field("manual_feed_out", due.manual_feed_out, out_o.manual_feed_out);
        compare_field("exit_out", due.exit_out, out_o.exit_out);
        compare_field("led_red", due.led_red, out_o.led_red);
        compare_field("led_yellow", due.led_yellow, out_o.led_yellow);
        compare_field("led_green", due.led_green, out_o.led_green);
        compare_field("phase", due.phase, out_o.phase);
      end
    end
    in_taken = rst_ni && in_valid && in_ready_o;
    if (in_taken) pins_due.push_back(advance_sequencer(in_data));
  end

  task automatic write_reg(cfg_idx_e idx, logic [DelayW-1:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgPowerOn:    timing.power_on_ms     = val;
      CfgClutch:     timing.clutch_ms       = val;
      CfgExitOn:     timing.exit_on_ms      = val;
      CfgManualOff:  timing.manual_off_ms   = val;
      CfgPaperInOff: timing.paper_in_off_ms = val;
      CfgExitOff:    timing.exit_off_ms     = val;
      CfgHallTmo:    timing.hall_timeout_ms = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_delays(int top_ms, int hall_lo, int hall_hi);
    for (int r = CfgPowerOn; r < CfgHallTmo; r++)
      write_reg(cfg_idx_e'(r), DelayW'($urandom_range(top_ms)));
    write_reg(CfgHallTmo, DelayW'($urandom_range(hall_hi, hall_lo)));
  endtask

  task automatic push_event(op_e op, logic paper);
    in_item_t ev;
    ev.op           = op;
    ev.paper_sensor = paper;
    event_backlog.push_back(ev);
    events_queued++;
  endtask

  // one sheet: motor start, clutch, paper arrives, sensor delays
  task automatic push_feed_cycle();
    int n;
    push_event(OpHall, 1'b0);
    n = capped(timing.clutch_ms) + $urandom_range(2);
    repeat (n) begin
      case ($urandom_range(15))
        0:       push_event(OpPanel, 1'($urandom_range(1)));
        1, 2, 3: push_event(OpHall, $urandom_range(3) == 0);
        default: push_event(OpTick, $urandom_range(3) == 0);
      endcase
    end
    repeat ($urandom_range(2)) push_event(OpTick, 1'b0);
    push_event(OpTick, 1'b1);
    n = capped(timing.exit_on_ms) + capped(timing.manual_off_ms) +
        capped(timing.paper_in_off_ms) + capped(timing.exit_off_ms) + $urandom_range(4);
    repeat (n) push_event(($urandom_range(3) == 0) ? OpHall : OpTick, 1'($urandom_range(1)));
    // now and then let the motor run down
    if ($urandom_range(3) == 0)
      repeat (capped(timing.hall_timeout_ms) + 2) push_event(OpTick, 1'($urandom_range(1)));
  endtask

  task automatic fill_random(int count);
    int stop;
    stop = events_queued + count;
    while (events_queued < stop) begin
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(5, 1))
          push_event(op_e'($urandom_range(3)), 1'($urandom_range(1)));
      end else begin
        push_feed_cycle();
      end
    end
  endtask

  // wait until every item has been sent and answered
  task automatic settle();
    while (event_backlog.size() > 0 || in_valid || pins_due.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    timing = '{power_on_ms: 16'd1000, clutch_ms: 16'd100, exit_on_ms: 16'd100,
               manual_off_ms: 16'd100, paper_in_off_ms: 16'd100, exit_off_ms: 16'd100,
               hall_timeout_ms: 16'd200};
    seq_state       = SqPowerOn;
    ms_elapsed      = '0;
    hall_age        = HallMax;
    pin_state       = '1;
    pin_state.phase = SqPowerOn;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 20;
    recv_idle_pct = 87;

    // a few events under the reset delays
    push_event(OpTick, 1'b0);
    push_event(OpHall, 1'b1);
    settle();

    // short delays, walk every phase and both panel aborts
    write_reg(CfgPowerOn, 16'd3);
    write_reg(CfgClutch, 16'd2);
    write_reg(CfgExitOn, 16'd1);
    write_reg(CfgManualOff, 16'd1);
    write_reg(CfgPaperInOff, 16'd2);
    write_reg(CfgExitOff, 16'd1);
    write_reg(CfgHallTmo, 16'd4);
    write_reg(CfgUnused, 16'hA5A5);
    push_event(OpPanel, 1'b0);
    push_event(OpNone, 1'b1);
    push_event(OpTick, 1'b0);
    push_event(OpTick, 1'b1);
    push_event(OpTick, 1'b1);
    push_event(OpHall, 1'b0);
    push_event(OpPanel, 1'b1);
    push_event(OpHall, 1'b0);
    push_event(OpTick, 1'b0);
    push_event(OpTick, 1'b0);
    push_event(OpPanel, 1'b1);
    push_event(OpHall, 1'b0);
    push_event(OpTick, 1'b0);
    push_event(OpTick, 1'b0);
    push_event(OpTick, 1'b1);
    push_event(OpTick, 1'b1);
    push_event(OpPanel, 1'b1);
    repeat (6) push_event(OpTick, 1'b1);
    settle();

    // zero delays advance one phase per event
    set_delays(0, 3, 3);
    push_event(OpHall, 1'b0);
    push_event(OpTick, 1'b0);
    push_event(OpTick, 1'b1);
    push_event(OpPanel, 1'b1);
    repeat (4) push_event(OpTick, 1'b1);
    settle();

    fill_random(600);
    settle();

    send_idle_pct = 87;
    recv_idle_pct = 20;
    // every register at its maximum, panel presses do the aborting
    for (int r = CfgPowerOn; r <= CfgHallTmo; r++) write_reg(cfg_idx_e'(r), '1);
    fill_random(150);
    settle();
    set_delays(8, 2, 16);
    fill_random(450);
    settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_delays(4, 1, 1);
    fill_random(650);
    // long receiver hold-off while the sender keeps offering
    hold_asked++;
    settle();

    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(3_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pfs_pkg.sv
rtl/pfs_cfg_regs.sv
rtl/pfs_seq_core.sv
rtl/paper_feed_sensor_sequencer.sv
rtl/pfs_checker.sv
verif/testbench.sv
